// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// The antecedent implies the consequent in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Operation codes and controller types of the byte deque with search.
// ----------------------------------------------------------------------------
package cdq_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_FIND       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_FIND,
      ST_EMIT
   } state_type;

   localparam int OpWidth   = 3;
   localparam int ByteWidth = 8;

endpackage

// ----- rtl/cdq_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AddrWidth-1:0] addr,
   input  logic [WIDTH-1:0]     wdata,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/char_deque_with_search_unit.sv -----
// ----------------------------------------------------------------------------
// char_deque_with_search_unit
// Bounded double-ended queue of bytes in a ring buffer, with a linear find.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (req_type, req_value_in) and each one
//   produces exactly one response on the rsp_ channel, both valid/ready.
//   The bytes live in a single-port RAM; front index and count are flops.
//   One request is in work at a time. A transfer is taken only in the idle
//   state, and the next one can follow in the cycle after the response is
//   loaded into the output register.
//   Push, a pop from an empty queue, an unknown code, and a find of the zero
//   byte or in an empty queue go from idle straight to the emit state; any
//   other pop makes one RAM read in the pop state, and any other find scans
//   from the front until the first match or through the whole occupancy;
//   the single RAM read port examines one entry per cycle. The response
//   register loads as the unit returns to idle, so rsp_valid and req_ready
//   rise together.
//   Reset empties the queue (front index and count to zero) and drops any
//   pending response; the RAM contents are not cleared.
//   When the receiver stalls, the response waits in the output register and
//   the unit finishes the next request, then holds it until the output frees.
// ----------------------------------------------------------------------------
module char_deque_with_search_unit
   import cdq_pkg::*;
#(
   parameter int CAPACITY = 64,
   localparam int PosWidth = $clog2(CAPACITY),
   localparam int CntWidth = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OpWidth-1:0]   req_type,
   input  logic [ByteWidth-1:0] req_value_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [ByteWidth-1:0] rsp_value_out,
   output logic                 rsp_found,
   output logic [PosWidth-1:0]  rsp_position,
   output logic [CntWidth-1:0]  rsp_occupancy
);

   localparam logic [PosWidth-1:0] LastIdx  = PosWidth'(CAPACITY - 1);
   localparam logic [CntWidth-1:0] CapCount = CntWidth'(CAPACITY);
   localparam logic [CntWidth:0]   CapWide  = (CntWidth + 1)'(CAPACITY);

   state_type state_ff, state_in;
   logic [PosWidth-1:0]  front_ff, front_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [PosWidth-1:0]  scan_ff, scan_in;
   logic [PosWidth-1:0]  ptr_ff, ptr_in;
   logic [ByteWidth-1:0] key_ff, key_in;
   logic                 st_ok_ff, st_ok_in;
   logic [ByteWidth-1:0] st_value_ff, st_value_in;
   logic                 st_found_ff, st_found_in;
   logic [PosWidth-1:0]  st_pos_ff, st_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [ByteWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [PosWidth-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CntWidth-1:0]  rsp_occ_ff, rsp_occ_in;

   logic                 ram_we;
   logic [PosWidth-1:0]  ram_addr;
   logic [ByteWidth-1:0] ram_rdata;

   logic [PosWidth-1:0]  front_inc, front_dec, ptr_inc, back_addr;
   logic [CntWidth-1:0]  back_off;
   logic [CntWidth:0]    back_sum;
   logic                 is_full, is_empty, out_free;

   cdq_ram #(
      .WIDTH(ByteWidth),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_value_in),
      .rdata(ram_rdata)
   );

   // Ring arithmetic: every sum that is used stays below twice the capacity, so one
   // compare and subtract wraps it.
   always_comb begin
      front_inc = (front_ff == LastIdx) ? '0 : front_ff + 1'b1;
      front_dec = (front_ff == '0) ? LastIdx : front_ff - 1'b1;
      ptr_inc   = (ptr_ff == LastIdx) ? '0 : ptr_ff + 1'b1;
      back_off  = (req_type == OP_POP_BACK) ? count_ff - 1'b1 : count_ff;
      back_sum  = (CntWidth + 1)'(front_ff) + (CntWidth + 1)'(back_off);
      back_addr = (back_sum >= CapWide) ? PosWidth'(back_sum - CapWide)
                                        : PosWidth'(back_sum);
      is_full   = (count_ff == CapCount);
      is_empty  = (count_ff == '0);
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      ptr_in       = ptr_ff;
      key_in       = key_ff;
      st_ok_in     = st_ok_ff;
      st_value_in  = st_value_ff;
      st_found_in  = st_found_ff;
      st_pos_in    = st_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_occ_in   = rsp_occ_ff;
      ram_we       = 1'b0;
      ram_addr     = ptr_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               st_ok_in    = 1'b0;
               st_value_in = '0;
               st_found_in = 1'b0;
               st_pos_in   = '0;
               key_in      = req_value_in;
               state_in    = ST_EMIT;
               case (req_type)
                  OP_PUSH_FRONT: begin
                     if (!is_full) begin
                        ram_we   = 1'b1;
                        ram_addr = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                        st_ok_in = 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (!is_full) begin
                        ram_we   = 1'b1;
                        ram_addr = back_addr;
                        count_in = count_ff + 1'b1;
                        st_ok_in = 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (!is_empty) begin
                        ram_addr = front_ff;
                        front_in = front_inc;
                        count_in = count_ff - 1'b1;
                        state_in = ST_POP;
                     end
                  end
                  OP_POP_BACK: begin
                     if (!is_empty) begin
                        ram_addr = back_addr;
                        count_in = count_ff - 1'b1;
                        state_in = ST_POP;
                     end
                  end
                  OP_FIND: begin
                     // The zero byte never matches.
                     if (req_value_in != '0 && !is_empty) begin
                        ram_addr = front_ff;
                        ptr_in   = front_inc;
                        scan_in  = '0;
                        state_in = ST_FIND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            st_ok_in    = 1'b1;
            st_value_in = ram_rdata;
            state_in    = ST_EMIT;
         end
         ST_FIND: begin
            // ram_rdata holds the entry at position scan_ff; the next read
            // is issued in the same cycle so one entry is examined per cycle.
            if (ram_rdata == key_ff) begin
               st_ok_in    = 1'b1;
               st_found_in = 1'b1;
               st_pos_in   = scan_ff;
               state_in    = ST_EMIT;
            end else if (CntWidth'(scan_ff) + 1'b1 == count_ff) begin
               state_in = ST_EMIT;
            end else begin
               ram_addr = ptr_ff;
               ptr_in   = ptr_inc;
               scan_in  = scan_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = st_ok_ff;
               rsp_value_in = st_value_ff;
               rsp_found_in = st_found_ff;
               rsp_pos_in   = st_pos_ff;
               rsp_occ_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      ptr_ff       <= ptr_in;
      key_ff       <= key_in;
      st_ok_ff     <= st_ok_in;
      st_value_ff  <= st_value_in;
      st_found_ff  <= st_found_in;
      st_pos_ff    <= st_pos_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

// ----- rtl/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the byte deque with search, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_checker #(
   parameter int CAPACITY = 64,
   localparam int PosWidth = $clog2(CAPACITY),
   localparam int CntWidth = $clog2(CAPACITY + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_ok,
   input logic [7:0]          rsp_value_out,
   input logic                rsp_found,
   input logic [PosWidth-1:0] rsp_position,
   input logic [CntWidth-1:0] rsp_occupancy
);

   localparam int PayloadWidth = 10 + PosWidth + CntWidth;

   logic [PayloadWidth-1:0] rsp_payload;
   logic                    rsp_stalled;
   logic                    found_ok;

   assign rsp_payload = {rsp_ok, rsp_value_out, rsp_found, rsp_position, rsp_occupancy};
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign found_ok    = (!rsp_found || rsp_ok) && (rsp_found || rsp_position == '0);

   // A stalled response keeps its payload.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

   // Only one request is in work, so a transfer always closes the input.
   `CHK_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)

   `CHK_IMPLY(a_occ_bound, clock, reset, rsp_valid, rsp_occupancy <= CntWidth'(CAPACITY))

   // A match is a success, and a miss reports position zero.
   `CHK_IMPLY(a_found_ok, clock, reset, rsp_valid, found_ok)

   // A nonzero popped byte only comes with success.
   `CHK_IMPLY(a_value_ok, clock, reset, rsp_valid && rsp_value_out != '0, rsp_ok && !rsp_found)

endmodule

bind char_deque_with_search_unit cdq_checker #(.CAPACITY(CAPACITY)) u_cdq_checker (.*);

// ----- verif/char_deque_with_search_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_deque_with_search_unit_tb
// Self-checking bench for the byte deque with search. A directed opening
// hits the empty, single-entry, zero-byte and unknown-code cases. Random
// fill, drain and mixed episodes follow, with random gaps on both channels.
// Every response is checked against an in-bench model of the ring.
// ----------------------------------------------------------------------------
module char_deque_with_search_unit_tb
   import cdq_pkg::*;
();

   localparam int Depth       = 64;
   localparam int ItemsWanted = 500;
   localparam int OpCodeMax   = (1 << OpWidth) - 1;
   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 100;
   localparam int ReportMax   = 10;

   typedef struct packed {
      logic [OpWidth-1:0]   code;
      logic [ByteWidth-1:0] data;
   } deque_req_type;

   typedef struct packed {
      logic                 ok;
      logic [ByteWidth-1:0] value_out;
      logic                 found;
      logic [5:0]           position;
      logic [6:0]           occupancy;
   } deque_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OpWidth-1:0]   req_type = '0;
   logic [ByteWidth-1:0] req_value_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_ok;
   logic [ByteWidth-1:0] rsp_value_out;
   logic                 rsp_found;
   logic [5:0]           rsp_position;
   logic [6:0]           rsp_occupancy;

   char_deque_with_search_unit #(
      .CAPACITY(Depth)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_value_in (req_value_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ok       (rsp_ok),
      .rsp_value_out(rsp_value_out),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_occupancy(rsp_occupancy)
   );

   always #2 clock = ~clock;

   deque_req_type stim_q[$];
   deque_rsp_type due_responses[$];
   int            mismatches = 0;
   int            valid_items = 0;

   // Shadow of the deque, updated once per accepted request.
   logic [ByteWidth-1:0] deque_bytes[Depth];
   logic [5:0]           head_idx = '0;
   int                   held_count = 0;

   function automatic deque_rsp_type apply_deque_op(logic [OpWidth-1:0] code,
                                                    logic [ByteWidth-1:0] data);
      deque_rsp_type r;
      logic [5:0] slot;
      r = '0;
      case (code)
         OP_PUSH_FRONT: begin
            if (held_count < Depth) begin
               head_idx = head_idx - 6'd1;
               deque_bytes[head_idx] = data;
               held_count++;
               r.ok = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (held_count < Depth) begin
               slot = head_idx + 6'(held_count);
               deque_bytes[slot] = data;
               held_count++;
               r.ok = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (held_count > 0) begin
               r.value_out = deque_bytes[head_idx];
               head_idx = head_idx + 6'd1;
               held_count--;
               r.ok = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (held_count > 0) begin
               slot = head_idx + 6'(held_count - 1);
               r.value_out = deque_bytes[slot];
               held_count--;
               r.ok = 1'b1;
            end
         end
         OP_FIND: begin
            // The zero byte is never reported as found, even when held.
            if (data != '0) begin
               for (int k = 0; k < held_count; k++) begin
                  slot = head_idx + 6'(k);
                  if (!r.found && deque_bytes[slot] == data) begin
                     r.found = 1'b1;
                     r.position = 6'(k);
                  end
               end
            end
            r.ok = r.found;
         end
         default: ;
      endcase
      r.occupancy = 7'(held_count);
      return r;
   endfunction

   // Mostly a small alphabet so that finds hit often, plus zero and full range.
   function automatic logic [ByteWidth-1:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7)
         return ByteWidth'($urandom_range(1, 12));
      else if (roll == 7)
         return '0;
      else
         return ByteWidth'($urandom_range(0, 255));
   endfunction

   function automatic void add_item(logic [OpWidth-1:0] code, logic [ByteWidth-1:0] data);
      stim_q.push_back('{code: code, data: data});
      if (code <= OP_FIND)
         valid_items++;
   endfunction

   function automatic logic [OpWidth-1:0] pick_pop();
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   function automatic logic [OpWidth-1:0] pick_push();
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   // Request driver: presents queued items, with a random gap before each.
   int   req_gap = 0;
   logic req_no_idle = 1'b0;

   always @(posedge clock) begin : req_driver
      deque_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (stim_q.size() > 0) begin
            cur = stim_q.pop_front();
            req_valid    <= 1'b1;
            req_type     <= cur.code;
            req_value_in <= cur.data;
            req_gap      <= req_no_idle ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0)
               req_no_idle <= !req_no_idle;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each transfer, then predicts from the request
   // side so that a same-edge request never matches an older response.
   int   rsp_stall = 0;
   logic rsp_no_idle = 1'b0;

   always @(posedge clock) begin : rsp_monitor
      deque_rsp_type got;
      deque_rsp_type want;
      int            draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{ok: rsp_ok, value_out: rsp_value_out, found: rsp_found,
                    position: rsp_position, occupancy: rsp_occupancy};
            if (due_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportMax)
                  $display("%0t: unexpected response ok=%0b val=%02h fnd=%0b pos=%0d occ=%0d",
                           $realtime, got.ok, got.value_out, got.found, got.position,
                           got.occupancy);
            end else begin
               want = due_responses.pop_front();
               if (got.ok !== want.ok || got.value_out !== want.value_out ||
                   got.found !== want.found || got.position !== want.position ||
                   got.occupancy !== want.occupancy) begin
                  mismatches++;
                  if (mismatches <= ReportMax) begin
                     $display("%0t: mismatch exp ok=%0b val=%02h fnd=%0b pos=%0d occ=%0d",
                              $realtime, want.ok, want.value_out, want.found,
                              want.position, want.occupancy);
                     $display("%0t:          got ok=%0b val=%02h fnd=%0b pos=%0d occ=%0d",
                              $realtime, got.ok, got.value_out, got.found,
                              got.position, got.occupancy);
                  end
               end
            end
            draw = rsp_no_idle ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0)
               rsp_no_idle <= !rsp_no_idle;
            if (draw == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               rsp_stall <= draw - 1;
            end
         end else if (!rsp_ready) begin
            if (rsp_stall > 0)
               rsp_stall <= rsp_stall - 1;
            else
               rsp_ready <= 1'b1;
         end
         if (req_valid && req_ready)
            due_responses.push_back(apply_deque_op(req_type, req_value_in));
      end
   end

   // Watchdog on cycles without any transfer.
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("char_deque_with_search_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int episode;
      int n;
      bit first_episode;
      first_episode = 1'b1;

      // Empty queue: failed pops, finds that see nothing, unknown codes.
      add_item(OP_POP_FRONT, 8'h3C);
      add_item(OP_POP_BACK, 8'hC3);
      add_item(OP_FIND, 8'h00);
      add_item(OP_FIND, 8'hFF);
      for (int c = OP_FIND + 1; c <= OpCodeMax; c++)
         add_item(OpWidth'(c), 8'hFF);
      // Build 5A A5 00 FF from the front, then search and take it apart.
      add_item(OP_PUSH_BACK, 8'h00);
      add_item(OP_PUSH_BACK, 8'hFF);
      add_item(OP_PUSH_FRONT, 8'hA5);
      add_item(OP_PUSH_FRONT, 8'h5A);
      add_item(OP_FIND, 8'hFF);
      add_item(OP_FIND, 8'h00);
      add_item(OP_FIND, 8'h5A);
      add_item(OP_FIND, 8'h77);
      add_item(OpWidth'(OpCodeMax), 8'h00);
      add_item(OP_POP_BACK, 8'h00);
      add_item(OP_POP_FRONT, 8'h00);
      add_item(OP_POP_BACK, 8'h00);
      add_item(OP_PUSH_BACK, 8'h81);
      add_item(OP_POP_BACK, 8'h00);
      add_item(OP_POP_FRONT, 8'h00);
      add_item(OP_POP_BACK, 8'h00);

      valid_items = 0;
      while (valid_items < ItemsWanted) begin
         episode = first_episode ? 0 : $urandom_range(0, 4);
         first_episode = 1'b0;
         case (episode)
            0: begin
               // Fill past capacity, search the full ring, then drain part way.
               n = $urandom_range(Depth + 2, Depth + 8);
               for (int i = 0; i < n; i++)
                  add_item(pick_push(), pick_byte());
               for (int i = 0; i < 3; i++)
                  add_item(OP_FIND, pick_byte());
               add_item(OP_FIND, ByteWidth'($urandom_range(13, 255)));
               n = $urandom_range(10, Depth + 4);
               for (int i = 0; i < n; i++)
                  add_item($urandom_range(0, 5) == 0 ? OP_FIND : pick_pop(), pick_byte());
            end
            1: begin
               n = $urandom_range(20, 70);
               for (int i = 0; i < n; i++)
                  add_item($urandom_range(0, 4) == 0 ? OP_FIND : pick_pop(), pick_byte());
            end
            default: begin
               n = $urandom_range(20, 40);
               for (int i = 0; i < n; i++) begin
                  case ($urandom_range(0, 19))
                     0:          add_item(OpWidth'($urandom_range(OP_FIND + 1, OpCodeMax)),
                                          ByteWidth'($urandom_range(0, 255)));
                     1, 2, 3, 4: add_item(OP_FIND, pick_byte());
                     5, 6, 7, 8, 9, 10, 11:
                                 add_item(pick_pop(), ByteWidth'($urandom_range(0, 255)));
                     default:    add_item(pick_push(), pick_byte());
                  endcase
               end
            end
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (stim_q.size() > 0 || req_valid || due_responses.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && due_responses.size() == 0)
         $display("char_deque_with_search_unit test passed");
      else
         $display("char_deque_with_search_unit test failed");
      $finish;
   end

endmodule

// ----- char_deque_with_search_unit.f -----
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/char_deque_with_search_unit.sv
rtl/cdq_checker.sv
verif/char_deque_with_search_unit_tb.sv
